[sv/i2c_seq_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types and constants for the tick-driven I2C master pin sequencer.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam logic [15:0] HALF_PERIOD_RESET    = 16'd5;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_ACK   = 3'd2,
        OP_NACK  = 3'd3,
        OP_WAIT  = 3'd4,
        OP_WRITE = 3'd5,
        OP_READ  = 3'd6
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S1, PH_S2, PH_S3,
        PH_P1, PH_P2,
        PH_A1, PH_A2, PH_A3, PH_A4,
        PH_N1, PH_N2,
        PH_W1, PH_WP, PH_WH, PH_WL, PH_WF,
        PH_RL, PH_RH, PH_RE,
        PH_XL, PH_XH
    } phase_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       ack_ok;
    } result_t;

endpackage

[sv/i2c_master_bit_sequencer_top.sv]
// Results enter the output register, or the skid entry while the head waits.
// Throughput: one tick request per cycle while in_ready is high; a two-entry
// output buffer keeps input acceptance going while one result waits.
// Reset: asynchronous, active low; the sequencer returns to idle with SCL and
// SDA driven high, half period 5 and poll limit 250.
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Advances the bus pin sequence by one tick for every accepted request and
// returns the pin levels and status after that tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [i2c_seq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2c_seq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd_valid,
    input  logic [2:0]                          operation,
    input  logic [7:0]                          write_data,
    input  logic                                sda_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                scl_level,
    output logic                                sda_level,
    output logic                                sda_drive,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [7:0]                          read_byte,
    output logic                                ack_ok
);

    localparam logic [2:0] LAST_BIT = 3'(i2c_seq_pkg::BITS_PER_BYTE - 1);

    logic [15:0]          half_period_reg;
    logic [7:0]           ack_poll_limit_reg;

    i2c_seq_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]          delay_reg, delay_next;
    logic [2:0]           bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           poll_reg, poll_next;
    logic [7:0]           rdata_reg, rdata_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 dir_reg, dir_next;
    logic                 ackf_reg, ackf_next;
    logic                 done_next;

    i2c_seq_pkg::result_t out_reg, out_next;
    i2c_seq_pkg::result_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    logic                 push;
    logic                 pop;
    logic                 start;
    logic                 step;
    logic                 poll_over;
    logic                 last_bit;
    logic [15:0]          hold;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    assign hold      = (half_period_reg == 16'd0) ? 16'd0 : half_period_reg - 16'd1;
    assign start     = (phase_reg == i2c_seq_pkg::PH_IDLE) && cmd_valid &&
                       (operation <= i2c_seq_pkg::OP_READ);
    assign step      = (phase_reg != i2c_seq_pkg::PH_IDLE) && (delay_reg == 16'd0);
    assign poll_over = poll_reg >= ack_poll_limit_reg;
    assign last_bit  = bit_reg == LAST_BIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg    <= i2c_seq_pkg::HALF_PERIOD_RESET;
            ack_poll_limit_reg <= i2c_seq_pkg::ACK_POLL_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                i2c_seq_pkg::CFG_HALF_PERIOD:    half_period_reg    <= cfg_data;
                i2c_seq_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_data[7:0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        done_next  = 1'b0;
        if (phase_reg == i2c_seq_pkg::PH_IDLE)
        begin
            if (start)
            begin
                delay_next = hold;
                case (i2c_seq_pkg::op_t'(operation))
                    i2c_seq_pkg::OP_START: phase_next = i2c_seq_pkg::PH_S1;
                    i2c_seq_pkg::OP_STOP:  phase_next = i2c_seq_pkg::PH_P1;
                    i2c_seq_pkg::OP_ACK:   phase_next = i2c_seq_pkg::PH_A1;
                    i2c_seq_pkg::OP_NACK:  phase_next = i2c_seq_pkg::PH_N1;
                    i2c_seq_pkg::OP_WAIT:  phase_next = i2c_seq_pkg::PH_W1;
                    i2c_seq_pkg::OP_WRITE: phase_next = i2c_seq_pkg::PH_XL;
                    default:               phase_next = i2c_seq_pkg::PH_RL;
                endcase
            end
        end
        else if (delay_reg != 16'd0)
        begin
            delay_next = delay_reg - 16'd1;
        end
        else
        begin
            delay_next = hold;
            case (phase_reg)
                i2c_seq_pkg::PH_S1: phase_next = i2c_seq_pkg::PH_S2;
                i2c_seq_pkg::PH_S2: phase_next = i2c_seq_pkg::PH_S3;
                i2c_seq_pkg::PH_P1: phase_next = i2c_seq_pkg::PH_P2;
                i2c_seq_pkg::PH_A1: phase_next = i2c_seq_pkg::PH_A2;
                i2c_seq_pkg::PH_A2: phase_next = i2c_seq_pkg::PH_A3;
                i2c_seq_pkg::PH_A3: phase_next = i2c_seq_pkg::PH_A4;
                i2c_seq_pkg::PH_N1: phase_next = i2c_seq_pkg::PH_N2;
                i2c_seq_pkg::PH_W1, i2c_seq_pkg::PH_WP:
                begin
                    if (!sda_in)
                        phase_next = i2c_seq_pkg::PH_WH;
                    else if (poll_over)
                        phase_next = i2c_seq_pkg::PH_WF;
                    else
                    begin
                        phase_next = i2c_seq_pkg::PH_WP;
                        delay_next = 16'd0;
                    end
                end
                i2c_seq_pkg::PH_WH: phase_next = i2c_seq_pkg::PH_WL;
                i2c_seq_pkg::PH_WF: phase_next = i2c_seq_pkg::PH_P1;
                i2c_seq_pkg::PH_RL: phase_next = i2c_seq_pkg::PH_RH;
                i2c_seq_pkg::PH_RH:
                    phase_next = last_bit ? i2c_seq_pkg::PH_RE : i2c_seq_pkg::PH_RL;
                i2c_seq_pkg::PH_XL: phase_next = i2c_seq_pkg::PH_XH;
                i2c_seq_pkg::PH_XH:
                begin
                    if (last_bit)
                    begin
                        phase_next = i2c_seq_pkg::PH_IDLE;
                        delay_next = 16'd0;
                        done_next  = 1'b1;
                    end
                    else
                        phase_next = i2c_seq_pkg::PH_XL;
                end
                default:
                begin
                    phase_next = i2c_seq_pkg::PH_IDLE;
                    delay_next = 16'd0;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        rdata_next = rdata_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        dir_next   = dir_reg;
        ackf_next  = ackf_reg;
        if (start)
        begin
            case (i2c_seq_pkg::op_t'(operation))
                i2c_seq_pkg::OP_START:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                i2c_seq_pkg::OP_STOP:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                i2c_seq_pkg::OP_ACK:  sda_next = 1'b0;
                i2c_seq_pkg::OP_NACK: scl_next = 1'b0;
                i2c_seq_pkg::OP_WAIT:
                begin
                    scl_next  = 1'b0;
                    dir_next  = 1'b0;
                    poll_next = 8'd0;
                end
                i2c_seq_pkg::OP_WRITE:
                begin
                    shift_next = write_data;
                    bit_next   = 3'd0;
                    scl_next   = 1'b0;
                    sda_next   = write_data[7];
                end
                default:
                begin
                    dir_next   = 1'b0;
                    shift_next = 8'd0;
                    bit_next   = 3'd0;
                    scl_next   = 1'b0;
                end
            endcase
        end
        else if (step)
        begin
            case (phase_reg)
                i2c_seq_pkg::PH_S1: sda_next = 1'b0;
                i2c_seq_pkg::PH_S2: scl_next = 1'b0;
                i2c_seq_pkg::PH_P1: sda_next = 1'b1;
                i2c_seq_pkg::PH_P2: scl_next = 1'b0;
                i2c_seq_pkg::PH_A1: scl_next = 1'b1;
                i2c_seq_pkg::PH_A2: scl_next = 1'b0;
                i2c_seq_pkg::PH_A3: sda_next = 1'b1;
                i2c_seq_pkg::PH_N1:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                i2c_seq_pkg::PH_W1, i2c_seq_pkg::PH_WP:
                begin
                    if (!sda_in)
                        scl_next = 1'b1;
                    else if (poll_over)
                    begin
                        dir_next  = 1'b1;
                        ackf_next = 1'b0;
                    end
                    else
                        poll_next = poll_reg + 8'd1;
                end
                i2c_seq_pkg::PH_WH: scl_next = 1'b0;
                i2c_seq_pkg::PH_WL:
                begin
                    dir_next  = 1'b1;
                    ackf_next = 1'b1;
                end
                i2c_seq_pkg::PH_WF:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                i2c_seq_pkg::PH_RL: scl_next = 1'b1;
                i2c_seq_pkg::PH_RH:
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    scl_next   = 1'b0;
                    if (last_bit)
                        dir_next = 1'b1;
                    else
                        bit_next = bit_reg + 3'd1;
                end
                i2c_seq_pkg::PH_RE: rdata_next = shift_reg;
                i2c_seq_pkg::PH_XL: scl_next = 1'b1;
                i2c_seq_pkg::PH_XH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (!last_bit)
                    begin
                        bit_next = bit_reg + 3'd1;
                        scl_next = 1'b0;
                        sda_next = shift_reg[6];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_next.scl_level = scl_next;
        out_next.sda_level = sda_next;
        out_next.sda_drive = dir_next;
        out_next.busy      = phase_next != i2c_seq_pkg::PH_IDLE;
        out_next.done      = done_next;
        out_next.read_byte = rdata_next;
        out_next.ack_ok    = ackf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2c_seq_pkg::PH_IDLE;
            delay_reg <= 16'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            rdata_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            dir_reg   <= 1'b1;
            ackf_reg  <= 1'b0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            rdata_reg <= rdata_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            dir_reg   <= dir_next;
            ackf_reg  <= ackf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= out_next;
        end
        else if (push)
            skid_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign scl_level = out_reg.scl_level;
    assign sda_level = out_reg.sda_level;
    assign sda_drive = out_reg.sda_drive;
    assign busy_res  = out_reg.busy;
    assign done_res  = out_reg.done;
    assign read_byte = out_reg.read_byte;
    assign ack_ok    = out_reg.ack_ok;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held without a head result.");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.done && out_reg.busy))
        else $error("Result reports done while still busy.");

    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2c_seq_pkg::PH_IDLE) |-> (delay_reg == 16'd0))
        else $error("Delay counter running while idle.");

    a_release_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_reg |-> (phase_reg == i2c_seq_pkg::PH_W1 || phase_reg == i2c_seq_pkg::PH_WP ||
                      phase_reg == i2c_seq_pkg::PH_WH || phase_reg == i2c_seq_pkg::PH_WL ||
                      phase_reg == i2c_seq_pkg::PH_RL || phase_reg == i2c_seq_pkg::PH_RH))
        else $error("SDA released outside an ack wait or a read.");

    a_push_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("Accepted request produced no result.");
`endif

endmodule
